[design/ihrf_pkg.sv]
`timescale 1ns / 1ps

package ihrf_pkg;

   // Result codes
   typedef enum logic [2:0] {
      VERDICT_ACCEPT = 3'd0,
      VERDICT_DEST   = 3'd1,
      VERDICT_FRAG   = 3'd2,
      VERDICT_CSUM   = 3'd3,
      VERDICT_HDR    = 3'd4
   } verdict_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_OWN_ADDRESS       = 2'd0;
   localparam logic [1:0] CSR_BROADCAST_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_FRAGMENTS_ALLOWED = 2'd2;

   localparam logic [31:0] OWN_ADDRESS_RESET       = 32'h0000_0000;
   localparam logic [31:0] BROADCAST_ADDRESS_RESET = 32'hFFFF_FFFF;
   localparam logic        FRAGMENTS_ALLOWED_RESET = 1'b0;

   // Byte positions of the fields inside the IPv4 header
   localparam logic [5:0] POS_VER_IHL  = 6'd0;
   localparam logic [5:0] POS_LEN_HI   = 6'd2;
   localparam logic [5:0] POS_LEN_LO   = 6'd3;
   localparam logic [5:0] POS_FRAG_HI  = 6'd6;
   localparam logic [5:0] POS_FRAG_LO  = 6'd7;
   localparam logic [5:0] POS_PROTOCOL = 6'd9;
   localparam logic [5:0] POS_SRC_0    = 6'd12;
   localparam logic [5:0] POS_SRC_1    = 6'd13;
   localparam logic [5:0] POS_SRC_2    = 6'd14;
   localparam logic [5:0] POS_SRC_3    = 6'd15;
   localparam logic [5:0] POS_DST_0    = 6'd16;
   localparam logic [5:0] POS_DST_1    = 6'd17;
   localparam logic [5:0] POS_DST_2    = 6'd18;
   localparam logic [5:0] POS_DST_3    = 6'd19;

   localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
   localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;

   typedef struct packed {
      logic [31:0] own_address;
      logic [31:0] broadcast_address;
      logic        fragments_allowed;
   } cfg_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] source_address;
      logic [7:0]  protocol_number;
      logic [15:0] payload_length;
   } result_type;

endpackage

[design/ipv4_header_rx_filter.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  packet_byte (8), frame_end (1)
// rsp_      out        rsp_valid / rsp_ready  verdict (3), source_address (32),
//                                             protocol_number (8), payload_length (16)
// csr_      in         csr_valid / csr_ready  index (2), data (32)
//
// One request per cycle unless a held result stalls the input. A byte waits
// in the input register; any result it makes is registered in the output register.
// Synchronous reset clears the packet state and loads the register defaults.
// A held result stalls only a byte that would make another result.
// Register writes are always taken.

module ipv4_header_rx_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_source_address,
   output logic [7:0]  rsp_protocol_number,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   ihrf_pkg::cfg_type    cfg;
   ihrf_pkg::result_type result;
   ihrf_pkg::result_type result_ff;
   logic                 emit;
   logic                 fire;
   logic                 out_free;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;
   logic                 out_valid_ff, out_valid_in;

   ihrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ihrf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .packet_byte (in_byte_ff),
      .frame_end   (in_end_ff),
      .cfg         (cfg),
      .emit        (emit),
      .result      (result)
   );

   // The held byte moves on unless its result has nowhere to go.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (out_free || !emit);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_packet_byte;
         in_end_ff  <= req_frame_end;
      end
      if (fire && emit) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_verdict         = result_ff.verdict;
   assign rsp_source_address  = result_ff.source_address;
   assign rsp_protocol_number = result_ff.protocol_number;
   assign rsp_payload_length  = result_ff.payload_length;

endmodule

[design/ihrf_csr.sv]
`timescale 1ns / 1ps

module ihrf_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output ihrf_pkg::cfg_type  cfg
);

   ihrf_pkg::cfg_type cfg_ff;
   ihrf_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ihrf_pkg::CSR_OWN_ADDRESS:       cfg_in.own_address       = csr_data;
            ihrf_pkg::CSR_BROADCAST_ADDRESS: cfg_in.broadcast_address = csr_data;
            ihrf_pkg::CSR_FRAGMENTS_ALLOWED: cfg_in.fragments_allowed = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address       <= ihrf_pkg::OWN_ADDRESS_RESET;
         cfg_ff.broadcast_address <= ihrf_pkg::BROADCAST_ADDRESS_RESET;
         cfg_ff.fragments_allowed <= ihrf_pkg::FRAGMENTS_ALLOWED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/ihrf_parser.sv]
`timescale 1ns / 1ps

module ihrf_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            packet_byte,
   input  logic                  frame_end,
   input  ihrf_pkg::cfg_type     cfg,
   output logic                  emit,
   output ihrf_pkg::result_type  result
);

   // Packet state
   logic [5:0]  byte_position_ff, byte_position_in;
   logic        header_done_ff, header_done_in;
   logic [15:0] sum_accumulator_ff, sum_accumulator_in;
   logic [7:0]  held_high_byte_ff, held_high_byte_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] flags_and_offset_ff, flags_and_offset_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] source_ff, source_in;
   logic [31:0] destination_ff, destination_in;

   // Values after this byte has been folded in
   logic [3:0]  upd_header_words;
   logic [15:0] upd_total_length;
   logic [15:0] upd_flags_and_offset;
   logic [7:0]  upd_protocol;
   logic [31:0] upd_source;
   logic [31:0] upd_destination;
   logic [7:0]  upd_held_high_byte;
   logic [15:0] upd_sum;
   logic [5:0]  upd_position;
   logic [16:0] sum_wide;
   logic [15:0] sum_fold;
   logic [5:0]  header_bytes;
   logic [15:0] header_bytes_wide;
   logic        short_header;
   logic        header_complete;
   logic        dest_bad;
   logic        is_fragment;

   // Field capture by byte position.
   always_comb begin
      upd_header_words     = header_words_ff;
      upd_total_length     = total_length_ff;
      upd_flags_and_offset = flags_and_offset_ff;
      upd_protocol         = protocol_ff;
      upd_source           = source_ff;
      upd_destination      = destination_ff;
      case (byte_position_ff)
         ihrf_pkg::POS_VER_IHL:  upd_header_words = packet_byte[3:0];
         ihrf_pkg::POS_LEN_HI:   upd_total_length[15:8] = packet_byte;
         ihrf_pkg::POS_LEN_LO:   upd_total_length[7:0] = packet_byte;
         ihrf_pkg::POS_FRAG_HI:  upd_flags_and_offset[15:8] = packet_byte;
         ihrf_pkg::POS_FRAG_LO:  upd_flags_and_offset[7:0] = packet_byte;
         ihrf_pkg::POS_PROTOCOL: upd_protocol = packet_byte;
         ihrf_pkg::POS_SRC_0, ihrf_pkg::POS_SRC_1,
         ihrf_pkg::POS_SRC_2, ihrf_pkg::POS_SRC_3:
            upd_source = {source_ff[23:0], packet_byte};
         ihrf_pkg::POS_DST_0, ihrf_pkg::POS_DST_1,
         ihrf_pkg::POS_DST_2, ihrf_pkg::POS_DST_3:
            upd_destination = {destination_ff[23:0], packet_byte};
         default: upd_header_words = header_words_ff;
      endcase
   end

   // One's-complement sum: even bytes are held, odd bytes complete a word.
   assign sum_wide = {1'b0, sum_accumulator_ff} + {1'b0, held_high_byte_ff, packet_byte};
   assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

   always_comb begin
      upd_held_high_byte = held_high_byte_ff;
      upd_sum            = sum_accumulator_ff;
      if (!byte_position_ff[0]) begin
         upd_held_high_byte = packet_byte;
      end else begin
         upd_sum = sum_fold;
      end
   end

   assign upd_position      = byte_position_ff + 6'd1;
   assign header_bytes      = {upd_header_words, 2'b00};
   assign header_bytes_wide = {10'd0, header_bytes};
   assign short_header      = upd_header_words < ihrf_pkg::MIN_HEADER_WORDS;
   assign header_complete   = upd_position == header_bytes;

   // A result comes with the last header byte, a bad length or an early end.
   assign emit = !header_done_ff && (short_header || header_complete || frame_end);

   // Verdict checks in priority order.
   assign dest_bad = (cfg.own_address != 32'd0)
                     && (upd_destination != cfg.own_address)
                     && (upd_destination != cfg.broadcast_address);
   // More-fragments flag or a nonzero offset marks a fragment.
   assign is_fragment = |upd_flags_and_offset[13:0];

   always_comb begin
      result.verdict         = ihrf_pkg::VERDICT_HDR;
      result.source_address  = 32'd0;
      result.protocol_number = 8'd0;
      result.payload_length  = 16'd0;
      if (!short_header && header_complete) begin
         if (dest_bad) begin
            result.verdict = ihrf_pkg::VERDICT_DEST;
         end else if (!cfg.fragments_allowed && is_fragment) begin
            result.verdict = ihrf_pkg::VERDICT_FRAG;
         end else if (upd_sum != ihrf_pkg::CHECKSUM_GOOD) begin
            result.verdict = ihrf_pkg::VERDICT_CSUM;
         end else begin
            result.verdict = ihrf_pkg::VERDICT_ACCEPT;
         end
         result.source_address  = upd_source;
         result.protocol_number = upd_protocol;
         if (upd_total_length > header_bytes_wide) begin
            result.payload_length = upd_total_length - header_bytes_wide;
         end
      end
   end

   // Next state: take the byte while the header runs, clear at frame end.
   always_comb begin
      byte_position_in    = byte_position_ff;
      header_done_in      = header_done_ff;
      sum_accumulator_in  = sum_accumulator_ff;
      held_high_byte_in   = held_high_byte_ff;
      header_words_in     = header_words_ff;
      total_length_in     = total_length_ff;
      flags_and_offset_in = flags_and_offset_ff;
      protocol_in         = protocol_ff;
      source_in           = source_ff;
      destination_in      = destination_ff;
      if (fire) begin
         if (!header_done_ff) begin
            byte_position_in    = upd_position;
            header_done_in      = short_header || header_complete;
            sum_accumulator_in  = upd_sum;
            held_high_byte_in   = upd_held_high_byte;
            header_words_in     = upd_header_words;
            total_length_in     = upd_total_length;
            flags_and_offset_in = upd_flags_and_offset;
            protocol_in         = upd_protocol;
            source_in           = upd_source;
            destination_in      = upd_destination;
         end
         if (frame_end) begin
            byte_position_in   = 6'd0;
            header_done_in     = 1'b0;
            sum_accumulator_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= 6'd0;
         header_done_ff     <= 1'b0;
         sum_accumulator_ff <= 16'd0;
      end else begin
         byte_position_ff   <= byte_position_in;
         header_done_ff     <= header_done_in;
         sum_accumulator_ff <= sum_accumulator_in;
      end
   end

   // Captured fields are always written before they are used.
   always_ff @(posedge clock) begin
      held_high_byte_ff   <= held_high_byte_in;
      header_words_ff     <= header_words_in;
      total_length_ff     <= total_length_in;
      flags_and_offset_ff <= flags_and_offset_in;
      protocol_ff         <= protocol_in;
      source_ff           <= source_in;
      destination_ff      <= destination_in;
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_BYTES = 145;
   localparam int LAST_PHASE  = 5;

   // One row of the directed table: a packet byte, and the verdict it must
   // produce when that verdict can be written down directly.
   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      logic                 typed;
      ihrf_pkg::result_type verdict_row;
   } stim_row_type;

   localparam ihrf_pkg::result_type NO_RESULT =
      '{ihrf_pkg::VERDICT_ACCEPT, 32'h0, 8'h0, 16'h0};
   localparam ihrf_pkg::result_type HDR_ERROR =
      '{ihrf_pkg::VERDICT_HDR, 32'h0, 8'h0, 16'h0};

   // Short headers, early frame ends, then one complete 20-byte header with a
   // good checksum addressed to broadcast.
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{8'h00, 1'b0, 1'b1, HDR_ERROR},   // IHL of zero fails at once
      '{8'hFF, 1'b1, 1'b0, NO_RESULT},   // ignored until the frame ends
      '{8'hFF, 1'b1, 1'b1, HDR_ERROR},   // IHL of 15, frame ends on byte 0
      '{8'h45, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1, HDR_ERROR},   // frame ends on byte 1
      '{8'h45, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h14, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h40, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h11, 1'b0, 1'b0, NO_RESULT},
      '{8'hBA, 1'b0, 1'b0, NO_RESULT},
      '{8'h30, 1'b0, 1'b0, NO_RESULT},
      '{8'hC0, 1'b0, 1'b0, NO_RESULT},
      '{8'hA8, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b0, NO_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_packet_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [31:0] rsp_source_address;
   logic [7:0]  rsp_protocol_number;
   logic [15:0] rsp_payload_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'h0;

   // Typed expectation that travels with the request currently offered.
   logic                 row_typed = 1'b0;
   ihrf_pkg::result_type row_expect = NO_RESULT;

   // Stimulus control
   bit          quiet = 1'b0;
   int          gap_odds = 8;
   logic [31:0] cur_own = ihrf_pkg::OWN_ADDRESS_RESET;
   logic [31:0] cur_bcast = ihrf_pkg::BROADCAST_ADDRESS_RESET;
   logic [7:0]  frame_bytes [$];

   // Predicted filter state
   ihrf_pkg::cfg_type filter_cfg;
   logic [5:0]  hp_pos;
   logic        hp_closed;
   logic [15:0] hp_sum;
   logic [7:0]  hp_high;
   logic [3:0]  hp_words;
   logic [15:0] hp_total;
   logic [15:0] hp_frag;
   logic [7:0]  hp_proto;
   logic [31:0] hp_src;
   logic [31:0] hp_dst;

   ihrf_pkg::result_type verdict_queue [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;

   ipv4_header_rx_filter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_packet_byte     (req_packet_byte),
      .req_frame_end       (req_frame_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_source_address  (rsp_source_address),
      .rsp_protocol_number (rsp_protocol_number),
      .rsp_payload_length  (rsp_payload_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic clear_packet_state();
      hp_pos    = 6'd0;
      hp_closed = 1'b0;
      hp_sum    = 16'h0;
      hp_high   = 8'h0;
      hp_words  = 4'h0;
      hp_total  = 16'h0;
      hp_frag   = 16'h0;
      hp_proto  = 8'h0;
      hp_src    = 32'h0;
      hp_dst    = 32'h0;
   endtask

   // Advance the header state by one byte and work out the verdict, if any.
   task automatic screen_header_byte(input logic [7:0] b, input logic last,
                                     output bit made, output ihrf_pkg::result_type res);
      logic [16:0] wide;
      logic [5:0]  hlen;
      made = 1'b0;
      res  = NO_RESULT;
      if (!hp_closed) begin
         case (hp_pos)
            ihrf_pkg::POS_VER_IHL:  hp_words = b[3:0];
            ihrf_pkg::POS_LEN_HI:   hp_total[15:8] = b;
            ihrf_pkg::POS_LEN_LO:   hp_total[7:0] = b;
            ihrf_pkg::POS_FRAG_HI:  hp_frag[15:8] = b;
            ihrf_pkg::POS_FRAG_LO:  hp_frag[7:0] = b;
            ihrf_pkg::POS_PROTOCOL: hp_proto = b;
            ihrf_pkg::POS_SRC_0, ihrf_pkg::POS_SRC_1,
            ihrf_pkg::POS_SRC_2, ihrf_pkg::POS_SRC_3:
               hp_src = {hp_src[23:0], b};
            ihrf_pkg::POS_DST_0, ihrf_pkg::POS_DST_1,
            ihrf_pkg::POS_DST_2, ihrf_pkg::POS_DST_3:
               hp_dst = {hp_dst[23:0], b};
            default: ;
         endcase
         // Even bytes are held; odd bytes complete a word for the checksum.
         if (!hp_pos[0]) begin
            hp_high = b;
         end else begin
            wide   = {1'b0, hp_sum} + {1'b0, hp_high, b};
            hp_sum = wide[15:0] + {15'h0, wide[16]};
         end
         hp_pos = hp_pos + 6'd1;
         hlen   = {hp_words, 2'b00};

         if (hp_words < ihrf_pkg::MIN_HEADER_WORDS) begin
            hp_closed = 1'b1;
            made      = 1'b1;
            res       = HDR_ERROR;
         end else if (hp_pos == hlen) begin
            hp_closed = 1'b1;
            made      = 1'b1;
            if (filter_cfg.own_address != 32'h0 && hp_dst != filter_cfg.own_address &&
                hp_dst != filter_cfg.broadcast_address) begin
               res.verdict = ihrf_pkg::VERDICT_DEST;
            end else if (!filter_cfg.fragments_allowed &&
                         (hp_frag[13] || hp_frag[12:0] != 13'h0)) begin
               res.verdict = ihrf_pkg::VERDICT_FRAG;
            end else if (hp_sum != ihrf_pkg::CHECKSUM_GOOD) begin
               res.verdict = ihrf_pkg::VERDICT_CSUM;
            end else begin
               res.verdict = ihrf_pkg::VERDICT_ACCEPT;
            end
            res.source_address  = hp_src;
            res.protocol_number = hp_proto;
            res.payload_length  = (hp_total > {10'h0, hlen}) ? hp_total - {10'h0, hlen} : 16'h0;
         end else if (last) begin
            made = 1'b1;
            res  = HDR_ERROR;
         end
      end
      if (last) begin
         clear_packet_state();
      end
   endtask

   // Check results against the oldest expectation, then track accepted
   // requests and register writes. A result never leaves in the cycle its
   // request is taken, so checking first is safe.
   always @(posedge clock) begin
      ihrf_pkg::result_type got;
      ihrf_pkg::result_type want;
      ihrf_pkg::result_type calc;
      bit                   made;
      if (reset) begin
         filter_cfg = '{ihrf_pkg::OWN_ADDRESS_RESET, ihrf_pkg::BROADCAST_ADDRESS_RESET,
                        ihrf_pkg::FRAGMENTS_ALLOWED_RESET};
         clear_packet_state();
         verdict_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.verdict         = ihrf_pkg::verdict_type'(rsp_verdict);
            got.source_address  = rsp_source_address;
            got.protocol_number = rsp_protocol_number;
            got.payload_length  = rsp_payload_length;
            if (verdict_queue.size() == 0) begin
               $error("unexpected result: verdict %0d", rsp_verdict);
               mismatch_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (got.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                  mismatch_count++;
               end
               if (got.source_address !== want.source_address) begin
                  $error("source_address: expected %h, got %h",
                         want.source_address, got.source_address);
                  mismatch_count++;
               end
               if (got.protocol_number !== want.protocol_number) begin
                  $error("protocol_number: expected %h, got %h",
                         want.protocol_number, got.protocol_number);
                  mismatch_count++;
               end
               if (got.payload_length !== want.payload_length) begin
                  $error("payload_length: expected %h, got %h",
                         want.payload_length, got.payload_length);
                  mismatch_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            screen_header_byte(req_packet_byte, req_frame_end, made, calc);
            if (row_typed) begin
               verdict_queue.push_back(row_expect);
            end else if (made) begin
               verdict_queue.push_back(calc);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               ihrf_pkg::CSR_OWN_ADDRESS:
                  filter_cfg.own_address = csr_data;
               ihrf_pkg::CSR_BROADCAST_ADDRESS:
                  filter_cfg.broadcast_address = csr_data;
               ihrf_pkg::CSR_FRAGMENTS_ALLOWED:
                  filter_cfg.fragments_allowed = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      int stall_left;
      if (reset || quiet) begin
         rsp_ready  <= !reset;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
      end
   end

   // Offer one packet byte and hold it until the request is taken.
   task automatic push_byte(input logic [7:0] b, input logic last,
                            input logic typed, input ihrf_pkg::result_type exp);
      req_valid       <= 1'b1;
      req_packet_byte <= b;
      req_frame_end   <= last;
      row_typed       <= typed;
      row_expect      <= exp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++) begin
         push_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_RESULT);
      end
   endtask

   // Build a mostly well-formed packet with random content into frame_bytes.
   task automatic build_packet(output int hlen);
      logic [7:0]  hdr [60];
      logic [3:0]  words;
      logic [15:0] tot;
      logic [15:0] frag;
      logic [15:0] sum;
      logic [16:0] wide;
      logic [31:0] dst;
      int          i;
      int          n;
      words = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
      hlen  = int'(words) * 4;
      for (i = 0; i < 60; i++) begin
         hdr[i] = 8'($urandom);
      end
      hdr[0] = ($urandom_range(0, 7) == 0) ? {4'($urandom), words} : {4'h4, words};

      // Total length: mostly sane, sometimes shorter than the header.
      case ($urandom_range(0, 9))
         0: tot = 16'($urandom);
         1: tot = 16'hFFFF;
         2: tot = 16'($urandom_range(0, hlen));
         3: tot = 16'h0000;
         default: tot = 16'(hlen + $urandom_range(0, 1400));
      endcase

      case ($urandom_range(0, 7))
         0, 1: frag = 16'h0000;
         2, 3: frag = 16'h4000;
         4: frag = 16'h2000 | 16'($urandom_range(0, 8191));
         5: frag = 16'($urandom_range(1, 8191));
         6: frag = 16'($urandom);
         default: frag = 16'hFFFF;
      endcase

      case ($urandom_range(0, 9))
         0, 1, 2, 3: dst = cur_own;
         4, 5: dst = cur_bcast;
         6: dst = 32'h0;
         default: dst = $urandom;
      endcase

      hdr[2]  = tot[15:8];
      hdr[3]  = tot[7:0];
      hdr[6]  = frag[15:8];
      hdr[7]  = frag[7:0];
      hdr[10] = 8'h00;
      hdr[11] = 8'h00;
      {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;

      // Fill in the checksum so the header sums to all ones, then
      // sometimes spoil it.
      sum = 16'h0;
      for (i = 0; i < hlen; i += 2) begin
         wide = {1'b0, sum} + {1'b0, hdr[i], hdr[i + 1]};
         sum  = wide[15:0] + {15'h0, wide[16]};
      end
      sum = ~sum;
      if ($urandom_range(0, 5) == 0) begin
         sum = sum ^ 16'($urandom_range(1, 65535));
      end
      hdr[10] = sum[15:8];
      hdr[11] = sum[7:0];

      frame_bytes.delete();
      for (i = 0; i < hlen; i++) begin
         frame_bytes.push_back(hdr[i]);
      end
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
         frame_bytes.push_back(8'($urandom));
      end
   endtask

   // Random frames for one phase: mostly well-formed, the rest truncated
   // headers, short IHL values and raw noise.
   task automatic run_random_frames(input int budget);
      int sent;
      int hlen;
      int kind;
      int n;
      int i;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            build_packet(hlen);
         end else if (kind < 85) begin
            build_packet(hlen);
            frame_bytes = frame_bytes[0:$urandom_range(0, hlen - 2)];
         end else if (kind < 92) begin
            frame_bytes.delete();
            frame_bytes.push_back({4'($urandom), 4'($urandom_range(0, 4))});
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) begin
               frame_bytes.push_back(8'($urandom));
            end
         end else begin
            frame_bytes.delete();
            n = $urandom_range(1, 30);
            for (i = 0; i < n; i++) begin
               frame_bytes.push_back(8'($urandom));
            end
         end
         send_frame();
         sent += frame_bytes.size();
      end
   endtask

   // Stop sending and wait until every expected verdict is back and the
   // pipeline has emptied.
   task automatic drain_filter(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_filter(input logic [31:0] own, input logic [31:0] bcast,
                                 input logic frag);
      write_reg(ihrf_pkg::CSR_OWN_ADDRESS, own);
      write_reg(ihrf_pkg::CSR_BROADCAST_ADDRESS, bcast);
      write_reg(ihrf_pkg::CSR_FRAGMENTS_ALLOWED, {31'($urandom), frag});
      csr_valid <= 1'b0;
      cur_own   = own;
      cur_bcast = bcast;
   endtask

   initial begin
      int i;
      int phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset defaults.
      for (i = 0; i < 25; i++) begin
         push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].verdict_row);
      end
      run_random_frames(PHASE_BYTES);

      // Each later phase runs under new register settings, extremes included.
      for (phase = 1; phase <= LAST_PHASE; phase++) begin
         drain_filter(4);
         case (phase)
            1: program_filter($urandom | 32'h1, 32'hFFFF_FFFF, 1'b0);
            2: program_filter(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
            3: program_filter(32'h0000_0000, $urandom, 1'b1);
            4: program_filter(32'h0000_0001, $urandom, 1'b0);
            default: program_filter($urandom, $urandom, 1'b1);
         endcase
         gap_odds = (phase % 2 == 0) ? 4 : 10;
         quiet    = (phase == LAST_PHASE);
         @(posedge clock);
         run_random_frames(PHASE_BYTES);
      end

      drain_filter(10);
      if (verdict_queue.size() != 0) begin
         $error("%0d verdicts never arrived", verdict_queue.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
